// ===== design/lprl_pkg.sv =====
// Shared types, constants and a helper function for the longest-prefix route lookup.
`default_nettype none

package lprl_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 4;
  localparam int INDEX_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int RANK_W     = 6;
  localparam int KEY_W      = RANK_W + 1;
  localparam int IN_TDATA_W = 144;
  localparam int OUT_TDATA_W = 48;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // One item as it moves down the side line beside the comparison tree.
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [INDEX_W-1:0] entry_index;
    logic [ADDR_W-1:0]  gateway;
    logic [PORT_W-1:0]  port;
  } item_t;

  // Number of one bits in a 32-bit word, summed as a balanced tree.
  function automatic logic [RANK_W-1:0] ones32(input logic [31:0] v);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) begin
      s1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
    end
    for (int i = 0; i < 8; i++) begin
      s2[i] = 3'(s1[2*i]) + 3'(s1[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      s3[i] = 4'(s2[2*i]) + 4'(s2[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      s4[i] = 5'(s3[2*i]) + 5'(s3[2*i+1]);
    end
    return RANK_W'(s4[0]) + RANK_W'(s4[1]);
  endfunction

endpackage

`default_nettype wire

// ===== design/longest_prefix_route_lookup.sv =====
// Top level of the IPv4 longest-prefix route lookup with its route table.
// A lookup passes, in order, the input stage, the leaf compare, each tree level and the
// output register; all of these stages advance together.
// Throughput: one item per cycle; the whole pipeline stalls only while a result waits.
// Reset clears the route count and every valid bit; route entries are undefined until
// loaded and there is no clearing pass.
`default_nettype none

module longest_prefix_route_lookup #(
  parameter int TABLE_DEPTH = lprl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration: route_count.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lprl_pkg::COUNT_W-1:0]      cfg_data,
  // Input channel.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata from bit 0: entry_index[5:0], route_prefix_in[37:6], route_mask_in[69:38],
  // next_hop_in[101:70], port_in[105:102], destination[137:106], zero fill.
  input  wire logic [lprl_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: kind.
  input  wire logic                              in_tuser,
  // Result channel.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata from bit 0: next_hop_out[31:0], port_out[35:32], match_index[41:36], zero fill.
  output logic      [lprl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser: found.
  output logic                                   out_tuser
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int LEAVES = 1 << IDX_W;
  localparam int HOP_W  = lprl_pkg::ADDR_W + lprl_pkg::PORT_W;

  // Input fields.
  logic [lprl_pkg::INDEX_W-1:0] in_entry_index;
  logic [lprl_pkg::ADDR_W-1:0]  in_prefix;
  logic [lprl_pkg::ADDR_W-1:0]  in_mask;
  logic [lprl_pkg::ADDR_W-1:0]  in_next_hop;
  logic [lprl_pkg::PORT_W-1:0]  in_port;
  logic [lprl_pkg::ADDR_W-1:0]  in_dest;

  assign in_entry_index = in_tdata[5:0];
  assign in_prefix      = in_tdata[37:6];
  assign in_mask        = in_tdata[69:38];
  assign in_next_hop    = in_tdata[101:70];
  assign in_port        = in_tdata[105:102];
  assign in_dest        = in_tdata[137:106];

  logic                          adv;
  logic                          in_xfer;
  logic                          load_xfer;
  logic [lprl_pkg::COUNT_W-1:0]  route_count_r;

  lprl_pkg::item_t               sa_item_r;
  lprl_pkg::item_t               sa_item_nxt;
  logic [lprl_pkg::ADDR_W-1:0]   sa_dest_r;
  lprl_pkg::item_t               side_r [IDX_W+1];

  logic [lprl_pkg::ADDR_W-1:0]   prefix_r [TABLE_DEPTH];
  logic [lprl_pkg::ADDR_W-1:0]   mask_r   [TABLE_DEPTH];
  logic [lprl_pkg::RANK_W-1:0]   rank_r   [TABLE_DEPTH];
  logic [lprl_pkg::RANK_W-1:0]   in_rank;
  logic [lprl_pkg::KEY_W-1:0]    leaf_key [LEAVES];

  logic [lprl_pkg::KEY_W-1:0]    root_key;
  logic [IDX_W-1:0]              root_idx;

  logic [HOP_W-1:0]              hop_mem [TABLE_DEPTH];
  logic [HOP_W-1:0]              hop_rd_r;
  logic                          mem_wr;
  logic [IDX_W-1:0]              mem_waddr;

  logic                          out_valid_r;
  logic                          out_found_r;
  logic [lprl_pkg::INDEX_W-1:0]  out_idx_r;
  logic [lprl_pkg::ADDR_W-1:0]   out_hop;
  logic [lprl_pkg::PORT_W-1:0]   out_port;

  // The whole pipeline moves together unless a finished result is still waiting.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_xfer   = in_tvalid && adv;
  assign load_xfer = in_xfer && (in_tuser == lprl_pkg::KIND_LOAD)
                     && (32'(in_entry_index) < TABLE_DEPTH);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_count_r <= '0;
    end else if (cfg_valid) begin
      route_count_r <= cfg_data;
    end
  end

  // Prefix, mask and rank are written on the load's transfer; a lookup compares in
  // the input stage after its own transfer, so it sees exactly the loads ahead of it.
  assign in_rank = lprl_pkg::ones32(in_mask);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (load_xfer && (32'(in_entry_index) == i)) begin
        prefix_r[i] <= in_prefix;
        mask_r[i]   <= in_mask;
        rank_r[i]   <= in_rank;
      end
    end

    logic hit;
    assign hit = (32'(i) < 32'(route_count_r)) && (prefix_r[i] == (sa_dest_r & mask_r[i]));
    assign leaf_key[i] = hit ? {1'b1, rank_r[i]} : '0;
  end

  for (genvar i = TABLE_DEPTH; i < LEAVES; i++) begin : g_pad
    assign leaf_key[i] = '0;
  end

  always_comb begin
    sa_item_nxt             = '0;
    sa_item_nxt.valid       = in_tvalid;
    sa_item_nxt.kind        = in_tuser;
    sa_item_nxt.entry_index = in_entry_index;
    sa_item_nxt.gateway     = in_next_hop;
    sa_item_nxt.port        = in_port;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_item_r.valid <= 1'b0;
    end else if (adv) begin
      sa_item_r <= sa_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_dest_r <= in_dest;
    end
  end

  // Side line that keeps each item level with its keys in the tree.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= IDX_W; k++) begin
        side_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      side_r[0] <= sa_item_r;
      for (int k = 1; k <= IDX_W; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  lprl_tree #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_tree (
    .clk       (clk),
    .en        (adv),
    .leaf_key_i(leaf_key),
    .root_key_o(root_key),
    .root_idx_o(root_idx)
  );

  // Next hop and port are written when the load reaches the end of the tree, the
  // same stage at which lookups read them, so order is kept without a hazard check.
  assign mem_wr = adv && side_r[IDX_W].valid && (side_r[IDX_W].kind == lprl_pkg::KIND_LOAD)
                  && (32'(side_r[IDX_W].entry_index) < TABLE_DEPTH);
  assign mem_waddr = IDX_W'(side_r[IDX_W].entry_index);

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      hop_mem[mem_waddr] <= {side_r[IDX_W].port, side_r[IDX_W].gateway};
    end
    if (adv) begin
      hop_rd_r <= hop_mem[root_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= side_r[IDX_W].valid && (side_r[IDX_W].kind == lprl_pkg::KIND_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_found_r <= root_key[lprl_pkg::KEY_W-1];
      out_idx_r   <= root_key[lprl_pkg::KEY_W-1] ? lprl_pkg::INDEX_W'(root_idx) : '0;
    end
  end

  assign out_hop    = out_found_r ? hop_rd_r[lprl_pkg::ADDR_W-1:0] : '0;
  assign out_port   = out_found_r ? hop_rd_r[HOP_W-1:lprl_pkg::ADDR_W] : '0;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {6'b0, out_idx_r, out_port, out_hop};

  // A lookup that leaves the tree on an advance is registered as a result.
  a_lookup_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    adv && side_r[IDX_W].valid && (side_r[IDX_W].kind == lprl_pkg::KIND_LOOKUP)
    |=> out_valid_r)
    else $error("lookup leaving the tree produced no result");

  // A load never turns into a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && side_r[IDX_W].valid && (side_r[IDX_W].kind == lprl_pkg::KIND_LOAD)
    |=> !out_valid_r)
    else $error("load item produced a result");

  // While the output waits, the front of the pipeline holds its item.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(side_r[0]) && $stable(sa_item_r))
    else $error("pipeline moved during a stall");

  // A reported match always names a slot that exists.
  a_match_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> (32'(out_idx_r) < TABLE_DEPTH))
    else $error("match index outside the route table");

endmodule

`default_nettype wire

// ===== design/lprl_tree.sv =====
// Registered priority tree that picks the matching route with the longest mask.
`default_nettype none

module lprl_tree #(
  parameter int TABLE_DEPTH = lprl_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W  = $clog2(TABLE_DEPTH),
  localparam int LEAVES = 1 << IDX_W
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [lprl_pkg::KEY_W-1:0] leaf_key_i [LEAVES],
  output logic      [lprl_pkg::KEY_W-1:0] root_key_o,
  output logic      [IDX_W-1:0]           root_idx_o
);

  logic [lprl_pkg::KEY_W-1:0] leaf_key_r [LEAVES];
  logic [lprl_pkg::KEY_W-1:0] node_key_r [1:LEAVES-1];
  logic [IDX_W-1:0]           node_idx_r [1:LEAVES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      leaf_key_r <= leaf_key_i;
    end
  end

  // Nodes are kept in heap order: node n combines nodes 2n and 2n+1. Every node is
  // a register, so each level of the tree is one pipeline stage.
  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    logic [lprl_pkg::KEY_W-1:0] lkey;
    logic [lprl_pkg::KEY_W-1:0] rkey;
    logic [IDX_W-1:0]           lidx;
    logic [IDX_W-1:0]           ridx;

    if (2 * n >= LEAVES) begin : g_from_leaf
      assign lkey = leaf_key_r[2*n-LEAVES];
      assign rkey = leaf_key_r[2*n+1-LEAVES];
      assign lidx = IDX_W'(2*n-LEAVES);
      assign ridx = IDX_W'(2*n+1-LEAVES);
    end else begin : g_from_node
      assign lkey = node_key_r[2*n];
      assign rkey = node_key_r[2*n+1];
      assign lidx = node_idx_r[2*n];
      assign ridx = node_idx_r[2*n+1];
    end

    // The key is {hit, rank}; on equal keys the left side holds the lower index.
    always_ff @(posedge clk) begin
      if (en) begin
        if (lkey >= rkey) begin
          node_key_r[n] <= lkey;
          node_idx_r[n] <= lidx;
        end else begin
          node_key_r[n] <= rkey;
          node_idx_r[n] <= ridx;
        end
      end
    end
  end

  assign root_key_o = node_key_r[1];
  assign root_idx_o = node_idx_r[1];

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the longest-prefix route lookup: directed tests, then random traffic.
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH       = 64;
  localparam int LATENCY     = 8;
  localparam int SETTLE      = LATENCY + 4;
  localparam int CYCLE_LIMIT = 600000;

  typedef logic [lprl_pkg::COUNT_W-1:0] count_t;
  typedef logic [lprl_pkg::INDEX_W-1:0] slot_t;
  typedef logic [lprl_pkg::PORT_W-1:0]  port_t;

  // Input tdata layout, highest field first.
  typedef struct packed {
    logic [5:0]                   pad;
    logic [lprl_pkg::ADDR_W-1:0]  dest;
    logic [lprl_pkg::PORT_W-1:0]  port;
    logic [lprl_pkg::ADDR_W-1:0]  gateway;
    logic [lprl_pkg::ADDR_W-1:0]  mask;
    logic [lprl_pkg::ADDR_W-1:0]  prefix;
    logic [lprl_pkg::INDEX_W-1:0] slot;
  } route_item_t;

  typedef struct packed {
    logic                         found;
    logic [lprl_pkg::INDEX_W-1:0] slot;
    logic [lprl_pkg::PORT_W-1:0]  port;
    logic [lprl_pkg::ADDR_W-1:0]  gateway;
  } route_answer_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [lprl_pkg::COUNT_W-1:0]     cfg_data   = '0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [lprl_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tuser   = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [lprl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;

  // Shadow copy of the route table and the active route count.
  logic [lprl_pkg::ADDR_W-1:0]  tbl_prefix  [DEPTH];
  logic [lprl_pkg::ADDR_W-1:0]  tbl_mask    [DEPTH];
  logic [lprl_pkg::ADDR_W-1:0]  tbl_gateway [DEPTH];
  logic [lprl_pkg::PORT_W-1:0]  tbl_port    [DEPTH];
  logic [lprl_pkg::COUNT_W-1:0] active_count = '0;

  route_answer_t pending_answers [$];
  int errors      = 0;
  int cycles      = 0;
  int ready_hold  = 0;
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;

  longest_prefix_route_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("longest_prefix_route_lookup regression: fail");
      $finish;
    end
  end

  function automatic int idle_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [lprl_pkg::ADDR_W-1:0] prefix_mask(input int len);
    return (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  function automatic route_answer_t predict_route(input logic [lprl_pkg::ADDR_W-1:0] dest);
    route_answer_t ans;
    int best_rank;
    int rank;
    int limit;
    ans       = '0;
    best_rank = -1;
    limit     = (active_count > DEPTH) ? DEPTH : int'(active_count);
    for (int i = 0; i < limit; i++) begin
      if (tbl_prefix[i] == (dest & tbl_mask[i])) begin
        rank = $countones(tbl_mask[i]);
        // Only a strictly longer mask displaces the winner, so ties stay with the lower slot.
        if (rank > best_rank) begin
          best_rank   = rank;
          ans.found   = 1'b1;
          ans.slot    = slot_t'(i);
          ans.port    = tbl_port[i];
          ans.gateway = tbl_gateway[i];
        end
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h, cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // Result receiver: ready is held high or low for runs of random length; with idle off it stays high.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_idle_on && out_tready) begin
      out_tready <= 1'b0;
      ready_hold <= idle_length() - 1;
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    route_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_tuser), 32'h0);
      end else begin
        want = pending_answers.pop_front();
        if (out_tuser !== want.found) begin
          report_mismatch("found", 32'(out_tuser), 32'(want.found));
        end
        if (out_tdata[31:0] !== want.gateway) begin
          report_mismatch("next_hop_out", out_tdata[31:0], want.gateway);
        end
        if (out_tdata[35:32] !== want.port) begin
          report_mismatch("port_out", 32'(out_tdata[35:32]), 32'(want.port));
        end
        if (out_tdata[41:36] !== want.slot) begin
          report_mismatch("match_index", 32'(out_tdata[41:36]), 32'(want.slot));
        end
      end
    end
  end

  task automatic send_item(input logic kind, input route_item_t item);
    int gap;
    gap = (in_idle_on && $urandom_range(0, 99) >= 55) ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = kind;
    in_tdata  = item;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == lprl_pkg::KIND_LOAD) begin
      tbl_prefix[item.slot]  = item.prefix;
      tbl_mask[item.slot]    = item.mask;
      tbl_gateway[item.slot] = item.gateway;
      tbl_port[item.slot]    = item.port;
    end else begin
      pending_answers.push_back(predict_route(item.dest));
    end
  endtask

  task automatic load_route(input logic [lprl_pkg::INDEX_W-1:0] slot,
                            input logic [lprl_pkg::ADDR_W-1:0] prefix,
                            input logic [lprl_pkg::ADDR_W-1:0] mask,
                            input logic [lprl_pkg::ADDR_W-1:0] gateway,
                            input logic [lprl_pkg::PORT_W-1:0] port);
    route_item_t item;
    item.pad     = '0;
    item.dest    = $urandom;
    item.port    = port;
    item.gateway = gateway;
    item.mask    = mask;
    item.prefix  = prefix;
    item.slot    = slot;
    send_item(lprl_pkg::KIND_LOAD, item);
  endtask

  // Route fields are filled with noise, which the block must ignore on a lookup.
  task automatic lookup(input logic [lprl_pkg::ADDR_W-1:0] dest);
    route_item_t item;
    item.pad     = '0;
    item.dest    = dest;
    item.port    = port_t'($urandom);
    item.gateway = $urandom;
    item.mask    = $urandom;
    item.prefix  = $urandom;
    item.slot    = slot_t'($urandom);
    send_item(lprl_pkg::KIND_LOOKUP, item);
  endtask

  // Routes often share their first one or two bytes so that prefixes nest and compete.
  task automatic load_random_route(input logic [lprl_pkg::INDEX_W-1:0] slot);
    logic [lprl_pkg::ADDR_W-1:0] base;
    logic [lprl_pkg::ADDR_W-1:0] mask;
    logic [lprl_pkg::ADDR_W-1:0] prefix;
    logic [7:0]                  top;
    int                          pick;
    case ($urandom_range(0, 3))
      0:       top = 8'h0A;
      1:       top = 8'hC0;
      2:       top = 8'hAC;
      default: top = 8'($urandom);
    endcase
    base = {top, ($urandom_range(0, 1) ? 8'h01 : 8'($urandom)), 16'($urandom)};
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      mask   = prefix_mask($urandom_range(0, 32));
      prefix = base & mask;
    end else if (pick == 8) begin
      mask   = $urandom;
      prefix = base & mask;
    end else begin
      // Host bits set beside the mask: this route can never match.
      mask   = prefix_mask($urandom_range(0, 31));
      prefix = (base & mask) | (~mask & ($urandom | 32'h1));
    end
    load_route(slot, prefix, mask, $urandom, port_t'($urandom));
  endtask

  task automatic lookup_random();
    int j;
    j = $urandom_range(0, DEPTH - 1);
    if ($urandom_range(0, 9) < 7) begin
      lookup(tbl_prefix[j] | ($urandom & ~tbl_mask[j]));
    end else begin
      lookup($urandom);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    // Loads give no result, so any still in the pipeline need time to finish.
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_route_count(input logic [lprl_pkg::COUNT_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    active_count = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_empty_table();
    write_route_count(7'd0);
    lookup(32'h0000_0000);
    lookup(32'hFFFF_FFFF);
  endtask

  task automatic test_directed_routes();
    load_route(6'd0, 32'h0000_0000, prefix_mask(0),  32'h0A00_0001, 4'd1);
    load_route(6'd1, 32'h0A00_0000, prefix_mask(8),  32'hFFFF_FFFF, 4'd15);
    load_route(6'd2, 32'h0A01_0000, prefix_mask(16), 32'h0A01_0001, 4'd2);
    load_route(6'd3, 32'h0A01_0200, prefix_mask(24), 32'h0A01_0201, 4'd3);
    load_route(6'd4, 32'h0A01_0200, prefix_mask(24), 32'h0A01_0202, 4'd4);
    load_route(6'd5, 32'h0A01_0203, prefix_mask(32), 32'h0000_0000, 4'd5);
    load_route(6'd6, 32'hC000_A800, 32'hFF00_FF00,   32'hC000_A801, 4'd6);
    load_route(6'd7, 32'hC0A8_0001, prefix_mask(24), 32'hC0A8_0002, 4'd7);
    write_route_count(7'd8);
    lookup(32'h0A01_0203);
    lookup(32'h0A01_0209);
    lookup(32'h0A01_0909);
    lookup(32'h0A09_0909);
    lookup(32'hC012_A834);
    lookup(32'hC0A8_0001);
    lookup(32'hFFFF_FFFF);
    // Replace the default route with a host route so that a miss is possible.
    load_route(6'd0, 32'h0000_0000, prefix_mask(32), 32'h0000_0000, 4'd0);
    lookup(32'h5555_5555);
    lookup(32'h0000_0000);
    write_route_count(7'd1);
    lookup(32'h0A01_0203);
  endtask

  task automatic test_fill_table();
    for (int s = 0; s < DEPTH; s++) begin
      load_random_route(slot_t'(s));
    end
    write_route_count(count_t'(DEPTH));
  endtask

  task automatic test_count_extremes();
    repeat (10) lookup_random();
    write_route_count(7'd127);
    repeat (10) lookup_random();
    write_route_count(count_t'(DEPTH + 1));
    repeat (5) lookup_random();
    write_route_count(7'd0);
    repeat (5) lookup_random();
  endtask

  task automatic test_random_traffic();
    logic [lprl_pkg::COUNT_W-1:0] count;
    for (int phase = 0; phase < 17; phase++) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       count = '0;
        1:       count = count_t'(DEPTH);
        2:       count = count_t'($urandom_range(DEPTH + 1, 127));
        default: count = count_t'($urandom_range(1, DEPTH - 1));
      endcase
      write_route_count(count);
      repeat (100) begin
        if ($urandom_range(0, 3) == 0) begin
          load_random_route(slot_t'($urandom_range(0, DEPTH - 1)));
        end else begin
          lookup_random();
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_table();
    test_directed_routes();
    test_fill_table();
    test_count_extremes();
    test_random_traffic();
    settle();
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("longest_prefix_route_lookup regression: pass");
    end else begin
      $display("longest_prefix_route_lookup regression: fail");
    end
    $finish;
  end

endmodule
